// ===== hw/rtl/rpts_pkg.sv =====
// ----------------------------------------------------------------------------
// rpts_pkg
// Shared widths, command codes and scan control type for the rotating
// priority task selector.
// ----------------------------------------------------------------------------
package rpts_pkg;

  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 3;
  localparam int PRIO_W  = 7;
  localparam int ENTRY_W = PRIO_W + 1;  // {asleep, priority}

  localparam logic [CMD_W-1:0] CMD_SCHEDULE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SLEEP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAKE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND_FREE = 3'd4;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;      // start of a new scan
    logic sample;     // read data of one slot is on the entry input
    logic find_mode;  // first free slot instead of highest priority
  } scan_ctl_t;

endpackage

// ===== hw/rtl/rpts_ram.sv =====
// ----------------------------------------------------------------------------
// rpts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q <= mem[ra];
    end
  end

endmodule

// ===== hw/rtl/rpts_scan.sv =====
// ----------------------------------------------------------------------------
// rpts_scan
// Scan unit: takes one slot entry per cycle from the table memory and keeps
// either the first free slot or the first slot with the highest nonzero awake
// priority.
// ----------------------------------------------------------------------------
module rpts_scan #(
  parameter int IDX_W = 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rpts_pkg::scan_ctl_t          ctl,
  input  logic [rpts_pkg::ENTRY_W-1:0] entry,
  input  logic [IDX_W-1:0]             idx,
  output logic                         hit,
  output logic [IDX_W-1:0]             best_idx
);

  logic [rpts_pkg::PRIO_W-1:0] best_prio;
  logic [rpts_pkg::PRIO_W-1:0] prio;
  logic                        asleep;
  logic                        take;

  assign prio   = entry[rpts_pkg::PRIO_W-1:0];
  assign asleep = entry[rpts_pkg::ENTRY_W-1];

  always_comb begin
    if (ctl.find_mode) begin
      take = !hit && (entry == '0);
    end else begin
      take = !asleep && (prio > best_prio);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.clear) begin
      hit <= 1'b0;
    end else if (ctl.sample && take) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_prio <= '0;
      best_idx  <= '0;
    end else if (ctl.sample && take) begin
      best_prio <= prio;
      best_idx  <= idx;
    end
  end

endmodule

// ===== hw/rtl/rotating_priority_task_selector.sv =====
// Schedule and find free: a scan over all SLOT_COUNT slots, one table
//   read per cycle through the single read port.
// Set priority, sleep, wake on a slot below SLOT_COUNT: read, write back, result.
// Reset clears all slot valid flags at once, so the table reads as empty;
//   the idle task is current. No clearing pass.
// ----------------------------------------------------------------------------
// rotating_priority_task_selector
// Task slot table in a RAM with a sequencer that scans it for scheduling and
// free-slot search and does read-modify-write for slot updates.
// ----------------------------------------------------------------------------
module rotating_priority_task_selector #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpts_pkg::CMD_W-1:0]  cmd,
  input  logic [rpts_pkg::SLOT_W-1:0] slot,
  input  logic [rpts_pkg::PRIO_W-1:0] priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rpts_pkg::SLOT_W-1:0] chosen_slot,
  output logic                        found,
  output logic                        is_idle
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int XW    = IDX_W + rpts_pkg::SLOT_W;
  localparam logic [XW-1:0]    SLOT_LIMIT = XW'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] WRAP_IDX   = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] SCAN_LEN   = CNT_W'(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WR   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [rpts_pkg::CMD_W-1:0]   cmd_r;
  logic [rpts_pkg::PRIO_W-1:0]  prio_r;
  logic [IDX_W-1:0]             slot_r;
  logic [IDX_W-1:0]             cur_slot;
  logic                         cur_idle;
  logic [IDX_W-1:0]             addr;
  logic [CNT_W-1:0]             cnt;
  logic                         smp;
  logic [IDX_W-1:0]             smp_idx;
  logic [SLOT_COUNT-1:0]        vld;
  logic                         rd_vld;

  logic                         accept;
  logic                         ld;
  logic                         issue;
  logic                         is_scan_cmd;
  logic                         is_rmw_cmd;
  logic [XW-1:0]                slot_x;
  logic                         slot_ok;
  logic [IDX_W-1:0]             slot_idx;
  logic [IDX_W-1:0]             next_after_cur;
  logic [IDX_W-1:0]             scan_start;

  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [rpts_pkg::ENTRY_W-1:0] ram_q;
  logic [rpts_pkg::ENTRY_W-1:0] entry_rd;
  logic                         we;
  logic [rpts_pkg::ENTRY_W-1:0] wd;

  rpts_pkg::scan_ctl_t          sctl;
  logic                         hit;
  logic [IDX_W-1:0]             best_idx;
  logic [XW-1:0]                best_x;
  logic                         res_found;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ld       = (state == S_DONE) && (!out_valid || out_ready);
  assign issue    = (state == S_SCAN) && (cnt != SCAN_LEN);

  assign slot_x   = {{IDX_W{1'b0}}, slot};
  assign slot_ok  = slot_x < SLOT_LIMIT;
  assign slot_idx = slot_x[IDX_W-1:0];

  assign next_after_cur = (cur_slot == WRAP_IDX) ? '0 : cur_slot + 1'b1;

  always_comb begin
    is_scan_cmd = 1'b0;
    is_rmw_cmd  = 1'b0;
    scan_start  = '0;
    unique case (cmd) inside
      rpts_pkg::CMD_SCHEDULE: begin
        is_scan_cmd = 1'b1;
        scan_start  = cur_idle ? '0 : next_after_cur;
      end
      rpts_pkg::CMD_FIND_FREE: begin
        is_scan_cmd = 1'b1;
      end
      rpts_pkg::CMD_SET_PRIO, rpts_pkg::CMD_SLEEP, rpts_pkg::CMD_WAKE: begin
        is_rmw_cmd = slot_ok;
      end
      default: begin
        is_scan_cmd = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_scan_cmd) begin
            state_next = S_SCAN;
          end else if (is_rmw_cmd) begin
            state_next = S_WR;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cnt == SCAN_LEN) begin
          state_next = S_DONE;
        end
      end
      S_WR: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (ld) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table port control
  assign rd_en    = (accept && is_rmw_cmd) || issue;
  assign rd_addr  = (state == S_IDLE) ? slot_idx : addr;
  assign entry_rd = rd_vld ? ram_q : '0;
  assign we       = (state == S_WR);

  always_comb begin
    case (cmd_r)
      rpts_pkg::CMD_SET_PRIO: wd = {1'b0, prio_r};
      rpts_pkg::CMD_SLEEP:    wd = {1'b1, entry_rd[rpts_pkg::PRIO_W-1:0]};
      default:                wd = {1'b0, entry_rd[rpts_pkg::PRIO_W-1:0]};
    endcase
  end

  rpts_ram #(
    .WIDTH (rpts_pkg::ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk (clk),
    .we  (we),
    .wa  (slot_r),
    .wd  (wd),
    .re  (rd_en),
    .ra  (rd_addr),
    .q   (ram_q)
  );

  assign sctl.clear     = accept && is_scan_cmd;
  assign sctl.sample    = smp;
  assign sctl.find_mode = (cmd_r == rpts_pkg::CMD_FIND_FREE);

  rpts_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sctl),
    .entry    (entry_rd),
    .idx      (smp_idx),
    .hit      (hit),
    .best_idx (best_idx)
  );

  assign best_x    = {{rpts_pkg::SLOT_W{1'b0}}, best_idx};
  assign res_found = hit && ((cmd_r == rpts_pkg::CMD_SCHEDULE) ||
                             (cmd_r == rpts_pkg::CMD_FIND_FREE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_idle  <= 1'b1;
      cur_slot  <= '0;
      out_valid <= 1'b0;
      smp       <= 1'b0;
      vld       <= '0;
    end else begin
      state <= state_next;
      smp   <= issue;
      if (we) begin
        vld[slot_r] <= 1'b1;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ld && (cmd_r == rpts_pkg::CMD_SCHEDULE)) begin
        cur_idle <= !hit;
        cur_slot <= hit ? best_idx : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd;
      prio_r <= priority_req;
      slot_r <= slot_idx;
      addr   <= scan_start;
      cnt    <= '0;
    end else if (issue) begin
      addr <= (addr == WRAP_IDX) ? '0 : addr + 1'b1;
      cnt  <= cnt + 1'b1;
    end
    if (issue) begin
      smp_idx <= addr;
    end
    if (rd_en) begin
      rd_vld <= vld[rd_addr];
    end
    if (ld) begin
      chosen_slot <= res_found ? best_x[rpts_pkg::SLOT_W-1:0] : '0;
      found       <= res_found;
      is_idle     <= (cmd_r == rpts_pkg::CMD_SCHEDULE) ? !hit : cur_idle;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(we && rd_en))
    else $error("table read and write in the same cycle");

  a_last_sample: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cnt == SCAN_LEN) |-> smp)
    else $error("scan ended without its last sample in flight");

  a_idle_no_sample: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !smp)
    else $error("sample pending while waiting for a transaction");

  a_sched_result: assert property (@(posedge clk) disable iff (rst)
    (ld && cmd_r == rpts_pkg::CMD_SCHEDULE) |=> (is_idle == !found))
    else $error("schedule result idle flag disagrees with found");

endmodule
